// ===== rtl/core/mcpu_pkg.sv =====
// Shared types, constants and the corner selection function for the upscaler.
// No dependencies; the upscaler top and mcpu_kernel import this package.
package mcpu_pkg;

    localparam int MAX_ROW_PIXELS = 1024;
    localparam int MAX_ROWS       = 4096;
    localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
    localparam int ROW_W          = $clog2(MAX_ROWS);
    localparam int PIX_W          = 32;
    localparam int LUMA_W         = 10;
    localparam int OUT_DATA_W     = 184;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SCALE      = 2'd2;
    localparam logic [1:0] CFG_DEST_WIDTH = 2'd3;

    // Window rows 0..2 (oldest row first), columns 0..2 (oldest column first).
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    // Which window cell is the centre, and which neighbors lie inside the frame.
    typedef struct packed {
        logic [1:0] mr;
        logic [1:0] mc;
        logic       up;
        logic       dn;
        logic       lf;
        logic       rt;
    } emit_sel_t;

    function automatic logic [LUMA_W-1:0] luma(input logic [PIX_W-1:0] c);
        luma = LUMA_W'(c[23:16]) + LUMA_W'(c[15:8]) + LUMA_W'(c[7:0]);
    endfunction

    // c: centre, a: first side, d: diagonal, b: second side.
    function automatic logic [PIX_W-1:0] corner(input logic [PIX_W-1:0] c,
                                                input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] d,
                                                input logic [PIX_W-1:0] b);
        logic [LUMA_W-1:0] cb;
        logic [LUMA_W-1:0] ab;
        logic [LUMA_W-1:0] db;
        logic [LUMA_W-1:0] bb;
        cb = luma(c);
        ab = luma(a);
        db = luma(d);
        bb = luma(b);
        if (cb <= ab && cb <= db && cb <= bb) begin
            if (ab <= db) begin
                corner = (ab <= bb) ? a : b;
            end else begin
                corner = (db <= bb) ? d : b;
            end
        end else if (cb <= ab || cb <= db || cb <= bb) begin
            corner = c;
        end else if (ab > db) begin
            corner = (ab > bb) ? a : b;
        end else begin
            corner = (db > bb) ? d : b;
        end
    endfunction

endpackage

// ===== rtl/core/median_corner_pixel_upscaler.sv =====
// Median corner pixel upscaler: accepts one pixel at a time, reads and
// rewrites both line stores, then emits zero to four results.
// Input is not ready again until every result of the last pixel is sent.
// Each pixel passes through the store read and write-back; each result
// through the two-step index multiply and an output state that holds
// while the output is not ready.
// Reset sets counters, window, mask and config registers; payload registers
// and line stores are not cleared and hold nothing valid until written.
// Depends on mcpu_pkg, mcpu_ram and mcpu_kernel.
module median_corner_pixel_upscaler (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [15:0]                         cfg_data,
    // Input stream; tdata: pixel_color[31:0].
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mcpu_pkg::PIX_W-1:0]          s_axis_tdata,
    // Output stream; tdata: center_x[9:0], center_y[21:10], dest_index[51:22],
    // write_enable[52], upper_left[84:53], upper_right[116:85],
    // lower_left[148:117], lower_right[180:149], zero[183:181].
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mcpu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);
    import mcpu_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_UPD  = 6'b000100,
        ST_EMA  = 6'b001000,
        ST_EMB  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t           state_reg;
    state_t           state_next;

    logic [10:0]      src_width_reg;
    logic [12:0]      src_height_reg;
    logic [4:0]       scale_reg;
    logic [14:0]      dest_width_reg;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] cx_reg;
    logic [ROW_W-1:0] cy_reg;
    logic [PIX_W-1:0] pix_reg;
    win_t             win_reg;
    logic [3:0]       mask_reg;

    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [COL_W-1:0] col_sat;
    logic [ROW_W-1:0] row_sat;
    logic             accept;

    logic [COL_W-1:0] ram_addr;
    logic             ram_we;
    logic [PIX_W-1:0] old_rdata;
    logic [PIX_W-1:0] new_rdata;

    logic [1:0]       pick;
    logic [3:0]       pick_bit;
    logic [COL_W-1:0] ex;
    logic [ROW_W-1:0] ey;
    emit_sel_t        sel;
    logic             k_we;
    logic [PIX_W-1:0] k_ul;
    logic [PIX_W-1:0] k_ur;
    logic [PIX_W-1:0] k_ll;
    logic [PIX_W-1:0] k_lr;

    logic [14:0]      sx_reg;
    logic [16:0]      sy_reg;
    logic [31:0]      idx_full;

    logic [COL_W-1:0] ox_reg;
    logic [ROW_W-1:0] oy_reg;
    logic [29:0]      oidx_reg;
    logic             owe_reg;
    logic [PIX_W-1:0] oul_reg;
    logic [PIX_W-1:0] our_reg;
    logic [PIX_W-1:0] oll_reg;
    logic [PIX_W-1:0] olr_reg;
    logic             olast_reg;

    // Effective geometry, held to the supported range.
    always_comb
    begin
        if (src_width_reg == 11'd0)
        begin
            wm1 = '0;
        end
        else if (src_width_reg > 11'(MAX_ROW_PIXELS))
        begin
            wm1 = COL_W'(MAX_ROW_PIXELS - 1);
        end
        else
        begin
            wm1 = COL_W'(src_width_reg - 11'd1);
        end
        if (src_height_reg == 13'd0)
        begin
            hm1 = '0;
        end
        else if (src_height_reg > 13'(MAX_ROWS))
        begin
            hm1 = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            hm1 = ROW_W'(src_height_reg - 13'd1);
        end
    end

    assign col_sat = (col_reg > wm1) ? wm1 : col_reg;
    assign row_sat = (row_reg > hm1) ? hm1 : row_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 11'd320;
            src_height_reg <= 13'd240;
            scale_reg      <= 5'd2;
            dest_width_reg <= 15'd640;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[10:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[12:0];
                CFG_SCALE:      scale_reg      <= cfg_data[4:0];
                CFG_DEST_WIDTH: dest_width_reg <= cfg_data[14:0];
                default:        src_width_reg  <= src_width_reg;
            endcase
        end
    end

    // Line stores: read at the accepted column, written back in the update state.
    assign ram_addr = (state_reg == ST_IDLE) ? col_sat : cx_reg;
    assign ram_we   = (state_reg == ST_UPD);

    mcpu_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_PIXELS)) u_older (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (new_rdata),
        .rdata (old_rdata)
    );

    mcpu_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_PIXELS)) u_newer (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (pix_reg),
        .rdata (new_rdata)
    );

    // Lowest pending result goes first.
    always_comb
    begin
        if (mask_reg[0])
        begin
            pick = 2'd0;
        end
        else if (mask_reg[1])
        begin
            pick = 2'd1;
        end
        else if (mask_reg[2])
        begin
            pick = 2'd2;
        end
        else
        begin
            pick = 2'd3;
        end
        pick_bit = 4'b0001 << pick;
        sel.mr   = pick[1] ? 2'd2 : 2'd1;
        sel.mc   = pick[0] ? 2'd2 : 2'd1;
        ex       = pick[0] ? wm1 : cx_reg - COL_W'(1);
        ey       = pick[1] ? cy_reg : cy_reg - ROW_W'(1);
        sel.up   = (ey != '0);
        sel.dn   = (ey < hm1);
        sel.lf   = (ex != '0);
        sel.rt   = (ex < wm1);
    end

    mcpu_kernel u_kernel (
        .win          (win_reg),
        .sel          (sel),
        .write_enable (k_we),
        .upper_left   (k_ul),
        .upper_right  (k_ur),
        .lower_left   (k_ll),
        .lower_right  (k_lr)
    );

    assign idx_full = sy_reg * dest_width_reg + 32'(sx_reg);

    // Control state machine.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RD;
            ST_RD:   state_next = ST_UPD;
            ST_UPD:  state_next = ST_EMA;
            ST_EMA:  state_next = (mask_reg == '0) ? ST_IDLE : ST_EMB;
            ST_EMB:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = (mask_reg == '0) ? ST_IDLE : ST_EMA;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            win_reg   <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cx_reg <= col_sat;
                cy_reg <= row_sat;
            end
            // Shift the window, compute pending results, advance position.
            if (state_reg == ST_UPD)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= old_rdata;
                win_reg[1][2] <= new_rdata;
                win_reg[2][2] <= pix_reg;
                mask_reg[0] <= (cy_reg != '0) && (cx_reg != '0);
                mask_reg[1] <= (cy_reg != '0) && (cx_reg == wm1);
                mask_reg[2] <= (cy_reg == hm1) && (cx_reg != '0);
                mask_reg[3] <= (cy_reg == hm1) && (cx_reg == wm1);
                if (cx_reg == wm1)
                begin
                    col_reg <= '0;
                    row_reg <= (cy_reg == hm1) ? '0 : cy_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= cx_reg + COL_W'(1);
                end
            end
            if (state_reg == ST_EMA)
            begin
                mask_reg <= mask_reg & ~pick_bit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= s_axis_tdata;
        end
        if (state_reg == ST_EMA)
        begin
            ox_reg    <= ex;
            oy_reg    <= ey;
            owe_reg   <= k_we;
            oul_reg   <= k_ul;
            our_reg   <= k_ur;
            oll_reg   <= k_ll;
            olr_reg   <= k_lr;
            olast_reg <= ((mask_reg & ~pick_bit) == '0);
            sx_reg    <= scale_reg * ex;
            sy_reg    <= scale_reg * ey;
        end
        if (state_reg == ST_EMB)
        begin
            oidx_reg <= idx_full[29:0];
        end
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {3'b000, olr_reg, oll_reg, our_reg, oul_reg, owe_reg,
                            oidx_reg, oy_reg, ox_reg};

    // A result is only shown in the output state.
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> state_reg == ST_OUT)
        else $error("output valid outside output state");

    // No new item is taken while results are still pending.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> mask_reg == '0)
        else $error("input ready with pending results");

    // Each emitted result retires exactly one pending bit.
    a_mask_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMA && mask_reg != '0) |=>
            $countones(mask_reg) == $countones($past(mask_reg)) - 1)
        else $error("pending mask did not drop by one");

endmodule

// ===== rtl/core/mcpu_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module mcpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read first: read data registered, showing the old word on a write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/mcpu_kernel.sv =====
// Corner color kernel: picks the centre and its neighbors out of the window
// with edge replication and forms the four corners. Uses mcpu_pkg.
module mcpu_kernel (
    input  mcpu_pkg::win_t             win,
    input  mcpu_pkg::emit_sel_t        sel,
    output logic                       write_enable,
    output logic [mcpu_pkg::PIX_W-1:0] upper_left,
    output logic [mcpu_pkg::PIX_W-1:0] upper_right,
    output logic [mcpu_pkg::PIX_W-1:0] lower_left,
    output logic [mcpu_pkg::PIX_W-1:0] lower_right
);
    import mcpu_pkg::*;

    logic [1:0]       ru;
    logic [1:0]       rd;
    logic [1:0]       cl;
    logic [1:0]       cr;
    logic [PIX_W-1:0] m;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] d;
    logic [PIX_W-1:0] l;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] ul_d;
    logic [PIX_W-1:0] ur_d;
    logic [PIX_W-1:0] dl_d;
    logic [PIX_W-1:0] dr_d;

    // Neighbor row and column indexes, held inside the window.
    assign ru = sel.mr - 2'd1;
    assign rd = (sel.mr == 2'd2) ? 2'd2 : sel.mr + 2'd1;
    assign cl = sel.mc - 2'd1;
    assign cr = (sel.mc == 2'd2) ? 2'd2 : sel.mc + 2'd1;

    // A neighbor outside the frame is replaced by the centre.
    assign m    = win[sel.mr][sel.mc];
    assign u    = sel.up ? win[ru][sel.mc] : m;
    assign d    = sel.dn ? win[rd][sel.mc] : m;
    assign l    = sel.lf ? win[sel.mr][cl] : m;
    assign r    = sel.rt ? win[sel.mr][cr] : m;
    assign ul_d = (sel.up && sel.lf) ? win[ru][cl] : m;
    assign ur_d = (sel.up && sel.rt) ? win[ru][cr] : m;
    assign dl_d = (sel.dn && sel.lf) ? win[rd][cl] : m;
    assign dr_d = (sel.dn && sel.rt) ? win[rd][cr] : m;

    // An unchanged pixel carries its own color in every corner.
    always_comb
    begin
        write_enable = !(m == u && m == l && m == r && m == d);
        if (write_enable)
        begin
            upper_left  = corner(m, l, ul_d, u);
            upper_right = corner(m, u, ur_d, r);
            lower_left  = corner(m, d, dl_d, l);
            lower_right = corner(m, r, dr_d, d);
        end
        else
        begin
            upper_left  = m;
            upper_right = m;
            lower_left  = m;
            lower_right = m;
        end
    end

endmodule
